@@ rtl/bqe_pkg.sv @@
// ----------------------------------------------------------------------------
// bqe_pkg
// Shared types and constants of the biquad cascade equalizer: coefficient
// packing, configuration register map and the shared MAC unit controls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bqe_pkg;

	// Default sizing, handed to the top level parameters
	localparam int BANDS_DEF        = 3;
	localparam int CHANNELS_DEF     = 2;
	localparam int SAMPLE_WIDTH_DEF = 24;

	// Coefficient format: Q4.17, three per 63-bit register
	localparam int COEF_BITS   = 21;
	localparam int COEF_FRAC   = 17;
	localparam int COEF_REGS   = 5;
	localparam int COEFS_PER   = 3;
	localparam int NCOEFS      = COEF_REGS * COEFS_PER;
	localparam int COEF_IDX_W  = $clog2(NCOEFS);
	localparam int TERMS       = 5;
	localparam int TERM_W      = 3;

	// Delay terms
	localparam int DELAY_W     = 32;

	// Configuration port
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = COEF_BITS * COEFS_PER;
	localparam int ACTIVE_W    = 2;
	localparam int unsigned ACTIVE_MAX = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF0  = 3'd0,
		REG_COEF1  = 3'd1,
		REG_COEF2  = 3'd2,
		REG_COEF3  = 3'd3,
		REG_COEF4  = 3'd4,
		REG_ACTIVE = 3'd5
	} cfg_reg_t;

	// Reset: b0 = 1.0 in every band, everything else zero
	localparam logic [CFG_DATA_W-1:0] COEF_RST [COEF_REGS] = '{
		63'd131072,
		63'd576460752303423488,
		63'd0,
		63'd274877906944,
		63'd0
	};
	localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 2'd2;

	// Term order inside a band
	typedef enum logic [TERM_W-1:0] {
		TERM_B0 = 3'd0,
		TERM_B1 = 3'd1,
		TERM_B2 = 3'd2,
		TERM_A1 = 3'd3,
		TERM_A2 = 3'd4
	} term_t;

	// Operation of the accumulate stage behind the shared multiplier
	typedef enum logic [2:0] {
		OP_NONE,
		OP_Y,        // y    = sat_S(r + d1)
		OP_SUM_D2,   // acc  = r + d2
		OP_D1,       // d1'  = sat32(acc - r)
		OP_SUM_ZERO, // acc  = r
		OP_D2        // d2'  = sat32(acc - r), combinational
	} mac_op_t;

	typedef struct packed {
		logic    load_x;  // take a new sample into x
		logic    step_x;  // band done: x = y
		logic    mul_y;   // multiplier operand is y instead of x
		mac_op_t op;
	} mac_ctrl_t;

endpackage

@@ rtl/biquad_cascade_equalizer_core.sv @@
// ----------------------------------------------------------------------------
// biquad_cascade_equalizer_core
// Three-band transposed direct form II biquad cascade on one shared MAC.
//
// Usage:
//  - Input channel (in_valid / in_stall): sample_in, channel, clear_history.
//    A transaction is taken only while the sequencer is idle.
//  - Output channel (out_valid / out_stall): sample_out, channel_out, held
//    in an output register, so a new input is taken while a result waits.
//  - Config port (cfg_we, cfg_index, cfg_data): write while idle.
//  - A filtered sample steps through ST_RD, ST_Y, ST_D1A, ST_D1B, ST_D2A
//    and ST_D2B per band on the single multiplier (read delay terms, five
//    products, write back), then ST_OUT loads the output register and
//    out_valid; the next input is taken back in ST_IDLE, so no new sample
//    is taken before the last one has left ST_OUT. A sample on an inactive
//    channel goes from ST_IDLE straight to ST_OUT.
//  - clear_history zeroes all delay terms at once through per-slot valid
//    bits; reset does the same and loads the identity coefficients.
//  - While the output is stalled with a result pending, a finished sample
//    waits in the final state and the input stays stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module biquad_cascade_equalizer_core #(
	parameter int BANDS        = bqe_pkg::BANDS_DEF,
	parameter int CHANNELS     = bqe_pkg::CHANNELS_DEF,
	parameter int SAMPLE_WIDTH = bqe_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input transactions
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	input  logic                           channel,
	input  logic                           clear_history,
	// output transactions
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out,
	output logic                           channel_out,
	// configuration writes
	input  logic                           cfg_we,
	input  logic [bqe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bqe_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bqe_pkg::*;

	localparam int SLOTS  = BANDS * CHANNELS;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int BAND_W = (BANDS > 1) ? $clog2(BANDS) : 1;
	localparam int RAM_W  = 2 * DELAY_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_Y,
		ST_D1A,
		ST_D1B,
		ST_D2A,
		ST_D2B,
		ST_OUT
	} state_t;

	state_t                         state_q;
	logic [BAND_W-1:0]              band_q;
	logic                           ch_q;
	logic [SLOTS-1:0]               vld_q;
	logic                           rd_vld_q;
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_out_q;
	logic                           channel_out_q;

	logic                           accept;
	logic                           ch_active;
	logic                           out_free;
	logic [SLOT_W-1:0]              slot;
	term_t                          term;
	mac_ctrl_t                      mac_ctrl;
	logic signed [COEF_BITS-1:0]    coef;
	logic [ACTIVE_W-1:0]            active_channels;
	logic [RAM_W-1:0]               ram_rdata;
	logic signed [DELAY_W-1:0]      d1_rd;
	logic signed [DELAY_W-1:0]      d2_rd;
	logic signed [SAMPLE_WIDTH-1:0] x;
	logic signed [DELAY_W-1:0]      d1_new;
	logic signed [DELAY_W-1:0]      d2_new;
	logic                           ram_we;
	logic                           ram_re;

	// Handshake and channel qualification
	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign ch_active = ({1'b0, channel} < active_channels)
		&& (32'(channel) < ACTIVE_MAX) && (32'(channel) < CHANNELS);
	assign slot      = SLOT_W'(int'(band_q) * CHANNELS + int'(ch_q));
	assign ram_re    = (state_q == ST_RD);
	assign ram_we    = (state_q == ST_D2B);

	// Delay terms of a slot never written since the last clear read as zero
	assign d1_rd = rd_vld_q ? $signed(ram_rdata[RAM_W-1:DELAY_W]) : '0;
	assign d2_rd = rd_vld_q ? $signed(ram_rdata[DELAY_W-1:0]) : '0;

	// Coefficient and MAC control for each sequencer step
	always_comb begin
		mac_ctrl        = '0;
		mac_ctrl.load_x = accept;
		mac_ctrl.op     = OP_NONE;
		term            = TERM_B0;
		unique case (state_q) inside
			ST_RD: begin
				term = TERM_B0;
			end
			ST_Y: begin
				term        = TERM_B1;
				mac_ctrl.op = OP_Y;
			end
			ST_D1A: begin
				term           = TERM_A1;
				mac_ctrl.mul_y = 1'b1;
				mac_ctrl.op    = OP_SUM_D2;
			end
			ST_D1B: begin
				term        = TERM_B2;
				mac_ctrl.op = OP_D1;
			end
			ST_D2A: begin
				term           = TERM_A2;
				mac_ctrl.mul_y = 1'b1;
				mac_ctrl.op    = OP_SUM_ZERO;
			end
			ST_D2B: begin
				mac_ctrl.op     = OP_D2;
				mac_ctrl.step_x = 1'b1;
			end
			ST_IDLE, ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	// Sequencer, valid bits and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			band_q        <= '0;
			ch_q          <= 1'b0;
			vld_q         <= '0;
			rd_vld_q      <= 1'b0;
			out_valid_q   <= 1'b0;
			sample_out_q  <= '0;
			channel_out_q <= 1'b0;
		end else begin
			// Output valid: set from the final state, cleared when taken
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ch_q   <= channel;
						band_q <= '0;
						if (clear_history) begin
							vld_q <= '0;
						end
						state_q <= ch_active ? ST_RD : ST_OUT;
					end
				end
				ST_RD: begin
					rd_vld_q <= vld_q[slot];
					state_q  <= ST_Y;
				end
				ST_Y:   state_q <= ST_D1A;
				ST_D1A: state_q <= ST_D1B;
				ST_D1B: state_q <= ST_D2A;
				ST_D2A: state_q <= ST_D2B;
				ST_D2B: begin
					vld_q[slot] <= 1'b1;
					if (band_q == BAND_W'(BANDS - 1)) begin
						state_q <= ST_OUT;
					end else begin
						band_q  <= band_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						sample_out_q  <= x;
						channel_out_q <= ch_q;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign sample_out  = sample_out_q;
	assign channel_out = channel_out_q;

	bqe_cfg #(
		.BANDS (BANDS)
	) u_cfg (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.band            (band_q),
		.term            (term),
		.coef            (coef),
		.active_channels (active_channels)
	);

	bqe_mac #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_mac (
		.clk    (clk),
		.ctrl   (mac_ctrl),
		.coef   (coef),
		.sample (sample_in),
		.d1_rd  (d1_rd),
		.d2_rd  (d2_rd),
		.x      (x),
		.d1_new (d1_new),
		.d2_new (d2_new)
	);

	// Delay terms: {delay_one, delay_two} per slot
	bqe_ram #(
		.WIDTH (RAM_W),
		.DEPTH (SLOTS)
	) u_delay_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot),
		.wdata ({d1_new, d2_new}),
		.re    (ram_re),
		.raddr (slot),
		.rdata (ram_rdata)
	);

`ifndef SYNTHESIS
	// A clear request leaves no slot holding old history
	a_clear_history: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && clear_history) |=> (vld_q == '0))
		else $error("delay history not cleared");

	// A result appears only from the final sequencer state
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_OUT))
		else $error("output loaded outside final state");

	// The band counter stays within the cascade while busy
	a_band_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (int'(band_q) < BANDS))
		else $error("band counter out of range");

	// A pending result is not overwritten while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(sample_out) && $stable(channel_out))
		else $error("stalled result overwritten");
`endif

endmodule

@@ rtl/bqe_ram.sv @@
// ----------------------------------------------------------------------------
// bqe_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bqe_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 6,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/bqe_cfg.sv @@
// ----------------------------------------------------------------------------
// bqe_cfg
// Configuration registers and coefficient selection for one band and term.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bqe_cfg #(
	parameter int BANDS  = bqe_pkg::BANDS_DEF,
	parameter int BAND_W = (BANDS > 1) ? $clog2(BANDS) : 1
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [bqe_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [bqe_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic [BAND_W-1:0]                     band,
	input  bqe_pkg::term_t                        term,
	output logic signed [bqe_pkg::COEF_BITS-1:0]  coef,
	output logic [bqe_pkg::ACTIVE_W-1:0]          active_channels
);
	import bqe_pkg::*;

	localparam int K_W = $clog2(BANDS * TERMS);

	logic [CFG_DATA_W-1:0] coef_q [COEF_REGS];
	logic [ACTIVE_W-1:0]   active_q;
	logic [COEF_BITS-1:0]  coefs [NCOEFS];
	logic [K_W-1:0]        k;
	logic [COEF_IDX_W-1:0] k_idx;

	// Register writes; indexes past the map are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q   <= COEF_RST;
			active_q <= ACTIVE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index) inside
				REG_COEF0, REG_COEF1, REG_COEF2, REG_COEF3, REG_COEF4: begin
					coef_q[cfg_index] <= cfg_data;
				end
				REG_ACTIVE: begin
					active_q <= cfg_data[ACTIVE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Unpack the fifteen coefficients, band-major order
	always_comb begin
		for (int i = 0; i < NCOEFS; i++) begin
			coefs[i] = coef_q[i / COEFS_PER][(i % COEFS_PER) * COEF_BITS +: COEF_BITS];
		end
	end

	// Coefficient k = band*5 + term; past the packed set it reads as zero
	assign k     = K_W'(int'(band) * TERMS + int'(term));
	assign k_idx = COEF_IDX_W'(k);
	assign coef  = (int'(k) < NCOEFS) ? $signed(coefs[k_idx]) : '0;

	assign active_channels = active_q;

endmodule

@@ rtl/bqe_mac.sv @@
// ----------------------------------------------------------------------------
// bqe_mac
// Shared multiply, round and accumulate unit of the biquad sequencer.
// One coefficient product per cycle, rounded by 17 bits, then summed and
// saturated as the sequencer asks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bqe_mac #(
	parameter int SAMPLE_WIDTH = bqe_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                 clk,
	input  bqe_pkg::mac_ctrl_t                   ctrl,
	input  logic signed [bqe_pkg::COEF_BITS-1:0] coef,
	input  logic signed [SAMPLE_WIDTH-1:0]       sample,
	input  logic signed [bqe_pkg::DELAY_W-1:0]   d1_rd,
	input  logic signed [bqe_pkg::DELAY_W-1:0]   d2_rd,
	output logic signed [SAMPLE_WIDTH-1:0]       x,
	output logic signed [bqe_pkg::DELAY_W-1:0]   d1_new,
	output logic signed [bqe_pkg::DELAY_W-1:0]   d2_new
);
	import bqe_pkg::*;

	localparam int PW   = COEF_BITS + SAMPLE_WIDTH;
	localparam int RW   = PW - COEF_FRAC;
	localparam int MW   = (RW > DELAY_W) ? RW : DELAY_W;
	localparam int SUMW = MW + 2;

	localparam logic signed [PW-1:0]   RND    = PW'(64'sd1 <<< (COEF_FRAC - 1));
	localparam logic signed [SUMW-1:0] S_HI   = SUMW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
	localparam logic signed [SUMW-1:0] S_LO   = -S_HI - SUMW'(1);
	localparam logic signed [SUMW-1:0] D_HI   = SUMW'((64'sd1 <<< (DELAY_W - 1)) - 64'sd1);
	localparam logic signed [SUMW-1:0] D_LO   = -D_HI - SUMW'(1);

	logic signed [PW-1:0]           p_q;
	logic signed [SUMW-1:0]         acc_q;
	logic signed [SAMPLE_WIDTH-1:0] y_q;
	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic signed [DELAY_W-1:0]      d1_q;
	logic signed [SAMPLE_WIDTH-1:0] opnd;
	logic signed [PW-1:0]           rsum;
	logic signed [RW-1:0]           r;
	logic signed [SUMW-1:0]         r_ext;
	logic signed [SUMW-1:0]         d1_ext;
	logic signed [SUMW-1:0]         d2_ext;
	logic signed [SUMW-1:0]         sum_y;
	logic signed [SUMW-1:0]         sum_d2;
	logic signed [SUMW-1:0]         diff;

	function automatic logic signed [SAMPLE_WIDTH-1:0] sat_s(input logic signed [SUMW-1:0] v);
		logic signed [SAMPLE_WIDTH-1:0] res;
		if (v > S_HI) begin
			res = S_HI[SAMPLE_WIDTH-1:0];
		end else if (v < S_LO) begin
			res = S_LO[SAMPLE_WIDTH-1:0];
		end else begin
			res = v[SAMPLE_WIDTH-1:0];
		end
		return res;
	endfunction

	function automatic logic signed [DELAY_W-1:0] sat_d(input logic signed [SUMW-1:0] v);
		logic signed [DELAY_W-1:0] res;
		if (v > D_HI) begin
			res = D_HI[DELAY_W-1:0];
		end else if (v < D_LO) begin
			res = D_LO[DELAY_W-1:0];
		end else begin
			res = v[DELAY_W-1:0];
		end
		return res;
	endfunction

	// Round half up: arithmetic shift of product plus half an LSB
	assign opnd   = ctrl.mul_y ? y_q : x_q;
	assign rsum   = p_q + RND;
	assign r      = rsum[PW-1:COEF_FRAC];
	assign r_ext  = {{(SUMW - RW){r[RW-1]}}, r};
	assign d1_ext = {{(SUMW - DELAY_W){d1_rd[DELAY_W-1]}}, d1_rd};
	assign d2_ext = {{(SUMW - DELAY_W){d2_rd[DELAY_W-1]}}, d2_rd};
	assign sum_y  = r_ext + d1_ext;
	assign sum_d2 = r_ext + d2_ext;
	assign diff   = acc_q - r_ext;

	// Multiplier register and accumulate stage
	always_ff @(posedge clk) begin
		p_q <= coef * opnd;
		case (ctrl.op)
			OP_Y:        y_q   <= sat_s(sum_y);
			OP_SUM_D2:   acc_q <= sum_d2;
			OP_D1:       d1_q  <= sat_d(diff);
			OP_SUM_ZERO: acc_q <= r_ext;
			default: begin
			end
		endcase
		if (ctrl.load_x) begin
			x_q <= sample;
		end else if (ctrl.step_x) begin
			x_q <= y_q;
		end
	end

	assign x      = x_q;
	assign d1_new = d1_q;
	assign d2_new = sat_d(diff);

endmodule
